/* rtl/cpno_pkg.sv */
package cpno_pkg;

   localparam int CoordWidth = 32;
   localparam int WideWidth  = 64;
   localparam int RootBits   = 32;
   localparam int QuoBits    = 32;
   localparam int AddrWidth  = 3;

   localparam logic [AddrWidth-1:0] ADDR_OFFSET_LENGTH = 3'd0;

   typedef struct packed {
      logic [CoordWidth-1:0] px;
      logic [CoordWidth-1:0] py;
      logic [CoordWidth-1:0] pz;
      logic [CoordWidth-1:0] offmag;
      logic [CoordWidth-1:0] ax;
      logic [CoordWidth-1:0] ay;
      logic [4:0]            sh;
      logic                  degen;
      logic                  negx;
      logic                  negy;
   } front_type;

   typedef struct packed {
      logic [CoordWidth-1:0] px;
      logic [CoordWidth-1:0] py;
      logic [CoordWidth-1:0] pz;
      logic                  degen;
      logic                  negx;
      logic                  negy;
   } point_type;

   typedef struct packed {
      point_type            pt;
      logic [WideWidth-1:0] prod_x;
      logic [WideWidth-1:0] prod_y;
   } sq_side_type;

endpackage

/* rtl/cpno_req_if.sv */
interface cpno_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cpno_pkg::CoordWidth-1:0] point_x;
   logic signed [cpno_pkg::CoordWidth-1:0] point_y;
   logic signed [cpno_pkg::CoordWidth-1:0] point_z;
   logic signed [cpno_pkg::CoordWidth-1:0] tangent_x;
   logic signed [cpno_pkg::CoordWidth-1:0] tangent_y;

   modport source (output valid, point_x, point_y, point_z, tangent_x, tangent_y,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, tangent_x, tangent_y,
                   output ready);
endinterface

/* rtl/cpno_rsp_if.sv */
interface cpno_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cpno_pkg::CoordWidth-1:0] left_x;
   logic signed [cpno_pkg::CoordWidth-1:0] left_y;
   logic signed [cpno_pkg::CoordWidth-1:0] right_x;
   logic signed [cpno_pkg::CoordWidth-1:0] right_y;
   logic signed [cpno_pkg::CoordWidth-1:0] out_z;
   logic                                 degenerate;
   logic                                 saturated;

   modport source (output valid, left_x, left_y, right_x, right_y, out_z, degenerate,
                   saturated, input ready);
   modport sink   (input valid, left_x, left_y, right_x, right_y, out_z, degenerate,
                   saturated, output ready);
endinterface

/* rtl/cpno_sqrt_pipe.sv */
module cpno_sqrt_pipe (
   input  logic                               clock,
   input  logic                               en,
   input  logic [cpno_pkg::WideWidth-1:0]     radicand,
   output logic [cpno_pkg::RootBits-1:0]      root
);

   logic [cpno_pkg::WideWidth-1:0] rem_ff [cpno_pkg::RootBits];
   logic [cpno_pkg::RootBits-1:0]  res_ff [cpno_pkg::RootBits];

   // one root bit per stage, msb first
   for (genvar k = 0; k < cpno_pkg::RootBits; k++) begin : g_stage
      localparam int Bit = cpno_pkg::RootBits - 1 - k;
      logic [cpno_pkg::WideWidth-1:0] rem_cur;
      logic [cpno_pkg::RootBits-1:0]  res_cur;
      logic [cpno_pkg::WideWidth-1:0] trial;
      logic [cpno_pkg::WideWidth-1:0] rem_in;
      logic [cpno_pkg::RootBits-1:0]  res_in;

      if (k == 0) begin : g_first
         assign rem_cur = radicand;
         assign res_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign res_cur = res_ff[k-1];
      end

      always_comb begin
         trial = ({{(cpno_pkg::WideWidth-cpno_pkg::RootBits){1'b0}}, res_cur} << (Bit + 1))
                 | ({{(cpno_pkg::WideWidth-1){1'b0}}, 1'b1} << (2 * Bit));
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            res_in = res_cur | ({{(cpno_pkg::RootBits-1){1'b0}}, 1'b1} << Bit);
         end else begin
            rem_in = rem_cur;
            res_in = res_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[cpno_pkg::RootBits-1];

endmodule

/* rtl/cpno_div_pipe.sv */
module cpno_div_pipe (
   input  logic                              clock,
   input  logic                              en,
   input  logic [cpno_pkg::WideWidth-1:0]    numer,
   input  logic [cpno_pkg::RootBits:0]       denom,
   output logic [cpno_pkg::QuoBits-1:0]      quot
);

   localparam int DenWidth = cpno_pkg::RootBits + 1;

   logic [cpno_pkg::WideWidth-1:0] rem_ff [cpno_pkg::QuoBits];
   logic [cpno_pkg::QuoBits-1:0]   quo_ff [cpno_pkg::QuoBits];
   logic [DenWidth-1:0]            den_ff [cpno_pkg::QuoBits];

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < cpno_pkg::QuoBits; k++) begin : g_stage
      localparam int Bit = cpno_pkg::QuoBits - 1 - k;
      logic [cpno_pkg::WideWidth-1:0] rem_cur;
      logic [cpno_pkg::QuoBits-1:0]   quo_cur;
      logic [DenWidth-1:0]            den_cur;
      logic [cpno_pkg::WideWidth-1:0] trial;
      logic [cpno_pkg::WideWidth-1:0] rem_in;
      logic [cpno_pkg::QuoBits-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign rem_cur = numer;
         assign quo_cur = '0;
         assign den_cur = denom;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      always_comb begin
         trial = {{(cpno_pkg::WideWidth-DenWidth){1'b0}}, den_cur} << Bit;
         if (rem_cur >= trial) begin
            rem_in = rem_cur - trial;
            quo_in = quo_cur | ({{(cpno_pkg::QuoBits-1){1'b0}}, 1'b1} << Bit);
         end else begin
            rem_in = rem_cur;
            quo_in = quo_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quot = quo_ff[cpno_pkg::QuoBits-1];

endmodule

/* rtl/curve_point_normal_offset.sv */
// throughput: one request per cycle while the output is not stalled; square root
//   and both divisions resolve one bit per pipeline stage (32 stages each)
// a stalled output freezes the pipeline; an empty first stage still takes a request
// reset (synchronous, active high) empties the pipeline and clears offset_length
module curve_point_normal_offset (
   input  logic                                  clock,
   input  logic                                  reset,
   cpno_req_if.sink                              req_bus,
   cpno_rsp_if.source                            rsp_bus,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [cpno_pkg::AddrWidth-1:0]        csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   localparam int CW = cpno_pkg::CoordWidth;
   localparam int WW = cpno_pkg::WideWidth;
   localparam int SqN = cpno_pkg::RootBits;
   localparam int DvN = cpno_pkg::QuoBits;

   logic [CW-1:0] offset_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == cpno_pkg::ADDR_OFFSET_LENGTH) ? offset_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr == cpno_pkg::ADDR_OFFSET_LENGTH) begin
         offset_ff <= csr_pwdata;
      end
   end

   // pipeline control
   logic en;
   logic ld1;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [SqN-1:0] vsq_ff;
   logic [DvN-1:0] vdv_ff;

   assign en  = !v7_ff || rsp_bus.ready;
   assign ld1 = en || !v1_ff;
   assign req_bus.ready = ld1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         vsq_ff <= '0;
         v6_ff  <= 1'b0;
         vdv_ff <= '0;
         v7_ff  <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= req_bus.valid;
         end
         if (en) begin
            v2_ff  <= v1_ff;
            v3_ff  <= v2_ff;
            v4_ff  <= v3_ff;
            v5_ff  <= v4_ff;
            vsq_ff <= {vsq_ff[SqN-2:0], v5_ff};
            v6_ff  <= vsq_ff[SqN-1];
            vdv_ff <= {vdv_ff[DvN-2:0], v6_ff};
            v7_ff  <= vdv_ff[DvN-1];
         end
      end
   end

   // stage 1: magnitudes and signs
   cpno_pkg::front_type s1_in, s1_ff;

   always_comb begin
      s1_in.px     = req_bus.point_x;
      s1_in.py     = req_bus.point_y;
      s1_in.pz     = req_bus.point_z;
      s1_in.offmag = offset_ff[CW-1] ? (~offset_ff + 1'b1) : offset_ff;
      s1_in.ax     = req_bus.tangent_x[CW-1] ? (~req_bus.tangent_x + 1'b1)
                                              : req_bus.tangent_x;
      s1_in.ay     = req_bus.tangent_y[CW-1] ? (~req_bus.tangent_y + 1'b1)
                                              : req_bus.tangent_y;
      s1_in.sh     = '0;
      s1_in.degen  = (req_bus.tangent_x == '0) && (req_bus.tangent_y == '0);
      // normal is (-ty, tx)
      s1_in.negx   = (offset_ff[CW-1] != (req_bus.tangent_y > 0)) &&
                     (offset_ff != '0) && (req_bus.tangent_y != '0);
      s1_in.negy   = (offset_ff[CW-1] != req_bus.tangent_x[CW-1]) &&
                     (offset_ff != '0) && (req_bus.tangent_x != '0);
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: normalizing shift amount
   cpno_pkg::front_type s2_in, s2_ff;
   logic [CW-1:0] mmax;

   always_comb begin
      s2_in = s1_ff;
      mmax  = (s1_ff.ax > s1_ff.ay) ? s1_ff.ax : s1_ff.ay;
      s2_in.sh = '0;
      for (int i = 0; i < CW - 1; i++) begin
         if (mmax[i]) begin
            s2_in.sh = 5'(CW - 2 - i);
         end
      end
      if (mmax[CW-1]) begin
         s2_in.sh = '0;
      end
   end

   // stage 3: shifted components
   cpno_pkg::front_type s3_in, s3_ff;

   always_comb begin
      s3_in    = s2_ff;
      s3_in.ax = s2_ff.ax << s2_ff.sh;
      s3_in.ay = s2_ff.ay << s2_ff.sh;
   end

   // stage 4: squares and offset products
   cpno_pkg::sq_side_type s4_side_in, s4_side_ff;
   logic [WW-1:0] sqx_in, sqx_ff, sqy_in, sqy_ff;

   always_comb begin
      s4_side_in.pt.px    = s3_ff.px;
      s4_side_in.pt.py    = s3_ff.py;
      s4_side_in.pt.pz    = s3_ff.pz;
      s4_side_in.pt.degen = s3_ff.degen;
      s4_side_in.pt.negx  = s3_ff.negx;
      s4_side_in.pt.negy  = s3_ff.negy;
      s4_side_in.prod_x   = WW'(s3_ff.offmag) * WW'(s3_ff.ay);
      s4_side_in.prod_y   = WW'(s3_ff.offmag) * WW'(s3_ff.ax);
      sqx_in              = WW'(s3_ff.ax) * WW'(s3_ff.ax);
      sqy_in              = WW'(s3_ff.ay) * WW'(s3_ff.ay);
   end

   // stage 5: sum of squares
   cpno_pkg::sq_side_type s5_side_ff;
   logic [WW-1:0] sumsq_in, sumsq_ff;

   assign sumsq_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_side_ff <= s4_side_in;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         s5_side_ff <= s4_side_ff;
         sumsq_ff   <= sumsq_in;
      end
   end

   // square root
   logic [SqN-1:0] root;
   cpno_pkg::sq_side_type sq_side_ff [SqN];

   cpno_sqrt_pipe u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sumsq_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_side_ff[0] <= s5_side_ff;
         for (int i = 1; i < SqN; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   // stage 6: rounded dividend and divisor
   cpno_pkg::point_type s6_pt_ff;
   logic [WW-1:0]  numx_in, numx_ff, numy_in, numy_ff;
   logic [SqN:0]   den_in, den_ff;

   always_comb begin
      numx_in = {sq_side_ff[SqN-1].prod_x[WW-2:0], 1'b0} + WW'(root);
      numy_in = {sq_side_ff[SqN-1].prod_y[WW-2:0], 1'b0} + WW'(root);
      den_in  = {root, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_pt_ff <= sq_side_ff[SqN-1].pt;
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         den_ff   <= den_in;
      end
   end

   // divisions
   logic [DvN-1:0] qx, qy;
   cpno_pkg::point_type dv_pt_ff [DvN];

   cpno_div_pipe u_div_x (
      .clock (clock),
      .en    (en),
      .numer (numx_ff),
      .denom (den_ff),
      .quot  (qx)
   );

   cpno_div_pipe u_div_y (
      .clock (clock),
      .en    (en),
      .numer (numy_ff),
      .denom (den_ff),
      .quot  (qy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dv_pt_ff[0] <= s6_pt_ff;
         for (int i = 1; i < DvN; i++) begin
            dv_pt_ff[i] <= dv_pt_ff[i-1];
         end
      end
   end

   // stage 7: offset sums with saturation, output register
   function automatic logic [CW:0] sat_sum(input logic [CW+1:0] s);
      logic [CW:0] r;
      begin
         if (s[CW+1:CW-1] == 3'b000 || s[CW+1:CW-1] == 3'b111) begin
            r = {1'b0, s[CW-1:0]};
         end else if (s[CW+1]) begin
            r = {1'b1, 1'b1, {(CW-1){1'b0}}};
         end else begin
            r = {1'b1, 1'b0, {(CW-1){1'b1}}};
         end
         return r;
      end
   endfunction

   cpno_pkg::point_type pt7;
   logic [CW+1:0] dx, dy, pxe, pye;
   logic [CW:0]   lx, ly, rx, ry;
   logic [CW-1:0] lx_in, ly_in, rx_in, ry_in, lx_ff, ly_ff, rx_ff, ry_ff, z_ff;
   logic          degen_ff, sat_in, sat_ff;

   always_comb begin
      pt7 = dv_pt_ff[DvN-1];
      dx  = pt7.negx ? -{2'b00, qx} : {2'b00, qx};
      dy  = pt7.negy ? -{2'b00, qy} : {2'b00, qy};
      pxe = {{2{pt7.px[CW-1]}}, pt7.px};
      pye = {{2{pt7.py[CW-1]}}, pt7.py};
      lx  = sat_sum(pxe + dx);
      ly  = sat_sum(pye + dy);
      rx  = sat_sum(pxe - dx);
      ry  = sat_sum(pye - dy);
      if (pt7.degen) begin
         lx_in  = pt7.px;
         ly_in  = pt7.py;
         rx_in  = pt7.px;
         ry_in  = pt7.py;
         sat_in = 1'b0;
      end else begin
         lx_in  = lx[CW-1:0];
         ly_in  = ly[CW-1:0];
         rx_in  = rx[CW-1:0];
         ry_in  = ry[CW-1:0];
         sat_in = lx[CW] | ly[CW] | rx[CW] | ry[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lx_ff    <= lx_in;
         ly_ff    <= ly_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         z_ff     <= pt7.pz;
         degen_ff <= pt7.degen;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_bus.valid      = v7_ff;
   assign rsp_bus.left_x     = lx_ff;
   assign rsp_bus.left_y     = ly_ff;
   assign rsp_bus.right_x    = rx_ff;
   assign rsp_bus.right_y    = ry_ff;
   assign rsp_bus.out_z      = z_ff;
   assign rsp_bus.degenerate = degen_ff;
   assign rsp_bus.saturated  = sat_ff;

   a_degen_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.degenerate |-> !rsp_bus.saturated)
      else $error("degenerate request reported saturation");

   a_degen_unmoved: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.degenerate |->
         rsp_bus.left_x == rsp_bus.right_x && rsp_bus.left_y == rsp_bus.right_y)
      else $error("degenerate request moved the point");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("request side stalled without output backpressure");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("output valid right after reset");

endmodule

/* tb/tb_curve_point_normal_offset.sv */
`timescale 1ns / 1ps

module tb_curve_point_normal_offset;

   typedef logic signed [cpno_pkg::CoordWidth-1:0] coord_type;

   typedef struct {
      coord_type left_x;
      coord_type left_y;
      coord_type right_x;
      coord_type right_y;
      coord_type out_z;
      logic      degenerate;
      logic      saturated;
   } offset_point_type;

   typedef struct {
      coord_type offset;
      coord_type px;
      coord_type py;
      coord_type pz;
      coord_type tx;
      coord_type ty;
      bit        typed;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [cpno_pkg::AddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   cpno_req_if req_if ();
   cpno_rsp_if rsp_if ();

   curve_point_normal_offset u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   offset_point_type expected_points[$];
   coord_type offset_reg;
   int errors;
   bit quiet;
   int rsp_count;
   int idle_cycles;

   stim_row_type rows[19] = '{
      '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000001, 32'h00000000, 1},
      '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'h12345678, 32'h80000000, 32'h7fffffff, 1},
      '{32'h00000000, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000000, 32'h00000000, 1},
      '{32'h7fffffff, 32'h00000000, 32'h00000000, 32'h00000005, 32'h00010000, 32'h00000000, 0},
      '{32'h7fffffff, 32'h7fffffff, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000001, 0},
      '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h00000000, 32'h80000000, 32'h80000000, 0},
      '{32'h7fffffff, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1},
      '{32'h7fffffff, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000003, 32'h00000004, 0},
      '{32'h7fffffff, 32'hffffffff, 32'h00000000, 32'h00000000, 32'h7fffffff, 32'h00000001, 0},
      '{32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h80000000, 0},
      '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h00000000, 32'h00000001, 32'h00000000, 0},
      '{32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h00000000, 32'hffffffff, 32'hffffffff, 0},
      '{32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1},
      '{32'h00010000, 32'h00100000, 32'h00200000, 32'h00300000, 32'h00030000, 32'h00040000, 0},
      '{32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000001, 32'h00000001, 0},
      '{32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h80000000, 32'h7fffffff, 0},
      '{32'hfffb0000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00010000, 0},
      '{32'hfffb0000, 32'h7fff0000, 32'h80010000, 32'h00000000, 32'h00010000, 32'h00000000, 0},
      '{32'hfffb0000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1}
   };

   coord_type phase_offsets[6] = '{32'h7fffffff, 32'h80000000, 32'h00000000,
                                   32'h00020000, 32'hffffffff, 32'h00000000};

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic coord_type clip_coord(input longint v, inout logic clipped);
      if (v > 64'sh7fffffff) begin
         clipped = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -64'sh80000000) begin
         clipped = 1'b1;
         return 32'h80000000;
      end
      return coord_type'(v);
   endfunction

   function automatic offset_point_type predict_offset(input coord_type px, input coord_type py,
                                                       input coord_type pz, input coord_type tx,
                                                       input coord_type ty, input coord_type off);
      offset_point_type r;
      longint unsigned ax, ay, m, sq, rem, root, bitv, offmag, qx, qy;
      longint dx, dy;
      logic clipped;
      r.left_x = px;
      r.left_y = py;
      r.right_x = px;
      r.right_y = py;
      r.out_z = pz;
      r.degenerate = (tx == 0) && (ty == 0);
      r.saturated = 1'b0;
      if (!r.degenerate) begin
         ax = (tx < 0) ? -longint'(tx) : longint'(tx);
         ay = (ty < 0) ? -longint'(ty) : longint'(ty);
         m = (ax > ay) ? ax : ay;
         while (m < (64'd1 << 30)) begin
            m = m << 1;
            ax = ax << 1;
            ay = ay << 1;
         end
         sq = ax * ax + ay * ay;
         rem = sq;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > sq) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (rem >= root + bitv) begin
               rem = rem - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         offmag = (off < 0) ? -longint'(off) : longint'(off);
         qx = (2 * offmag * ay + root) / (2 * root);
         qy = (2 * offmag * ax + root) / (2 * root);
         // normal is (-ty, tx)
         dx = (off != 0 && ty != 0 && ((off < 0) != (ty > 0))) ? -longint'(qx) : longint'(qx);
         dy = (off != 0 && tx != 0 && ((off < 0) != (tx < 0))) ? -longint'(qy) : longint'(qy);
         clipped = 1'b0;
         r.left_x = clip_coord(longint'(px) + dx, clipped);
         r.left_y = clip_coord(longint'(py) + dy, clipped);
         r.right_x = clip_coord(longint'(px) - dx, clipped);
         r.right_y = clip_coord(longint'(py) - dy, clipped);
         r.saturated = clipped;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input coord_type got,
                                  input coord_type want);
      $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
      errors++;
   endtask

   task automatic write_offset(input coord_type value);
      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= cpno_pkg::ADDR_OFFSET_LENGTH;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      offset_reg = value;
      @(posedge clock);
   endtask

   task automatic send_point(input coord_type px, input coord_type py, input coord_type pz,
                             input coord_type tx, input coord_type ty, input bit typed);
      offset_point_type e;
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.point_x <= px;
      req_if.point_y <= py;
      req_if.point_z <= pz;
      req_if.tangent_x <= tx;
      req_if.tangent_y <= ty;
      do @(posedge clock); while (!req_if.ready);
      if (typed) begin
         e.left_x = px;
         e.left_y = py;
         e.right_x = px;
         e.right_y = py;
         e.out_z = pz;
         e.degenerate = (tx == 0) && (ty == 0);
         e.saturated = 1'b0;
      end else begin
         e = predict_offset(px, py, pz, tx, ty, offset_reg);
      end
      expected_points.push_back(e);
   endtask

   // stimulus
   initial begin
      coord_type px, py, pz, tx, ty;
      errors = 0;
      quiet = 0;
      offset_reg = '0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      req_if.point_z = '0;
      req_if.tangent_x = '0;
      req_if.tangent_y = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].offset != offset_reg) write_offset(rows[i].offset);
         send_point(rows[i].px, rows[i].py, rows[i].pz, rows[i].tx, rows[i].ty,
                    rows[i].typed);
      end

      foreach (phase_offsets[p]) begin
         write_offset((p == 2) ? coord_type'($urandom) : phase_offsets[p]);
         if (p == 5) quiet = 1;
         for (int n = 0; n < 325; n++) begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
            tx = $urandom;
            ty = $urandom;
            case ($urandom_range(0, 9))
               0: begin
                  tx = 0;
                  ty = 0;
               end
               1: tx = 0;
               2: ty = 0;
               3: begin
                  tx = $signed($urandom_range(0, 15)) - 8;
                  ty = $signed($urandom_range(0, 15)) - 8;
               end
               4: begin
                  px = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                  py = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
               end
               5: begin
                  tx = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
                  ty = $urandom_range(0, 1) ? 32'h80000000 : coord_type'($urandom_range(0, 3));
               end
               default: ;
            endcase
            send_point(px, py, pz, tx, ty, 0);
         end
      end

      req_if.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // result side: checking and backpressure
   initial begin
      offset_point_type e;
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_count = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (rsp_count == 400) hold_left = 300;
            if (expected_points.size() == 0) begin
               $display("unexpected request result at %0t", $realtime);
               errors++;
            end else begin
               e = expected_points.pop_front();
               if (rsp_if.left_x !== e.left_x) report_mismatch("left_x", rsp_if.left_x, e.left_x);
               if (rsp_if.left_y !== e.left_y) report_mismatch("left_y", rsp_if.left_y, e.left_y);
               if (rsp_if.right_x !== e.right_x)
                  report_mismatch("right_x", rsp_if.right_x, e.right_x);
               if (rsp_if.right_y !== e.right_y)
                  report_mismatch("right_y", rsp_if.right_y, e.right_y);
               if (rsp_if.out_z !== e.out_z) report_mismatch("out_z", rsp_if.out_z, e.out_z);
               if (rsp_if.degenerate !== e.degenerate)
                  report_mismatch("degenerate", rsp_if.degenerate, e.degenerate);
               if (rsp_if.saturated !== e.saturated)
                  report_mismatch("saturated", rsp_if.saturated, e.saturated);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= 3000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule
